// File: src/plin_pkg.sv
// Package for the piecewise linear interpolator.
// Holds the shared item type, status codes, FSM states and sizing constants.
// No dependencies.
package plin_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BEYOND     = 2'd1;
    localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;
    localparam logic [1:0] ST_SAT        = 2'd3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic               load_ok;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_position;
        logic signed [31:0] entry_temperature;
        logic signed [31:0] query_position;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// File: src/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to MAX_POINTS breakpoints.
// A load writes the table once the idle back end takes it from the front queue;
// a query scans the breakpoints, then uses the shift-add multiply and restoring divide unit.
// Queries are processed one at a time; the front queue holds two items.
// Reset (synchronous, active low) empties both queues; the table is not cleared.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_mode,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_entry_position,
    input  logic signed [31:0] i_entry_temperature,
    input  logic signed [31:0] i_query_position,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_temperature,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);

    logic            w_valid, w_pop;
    plin_pkg::t_item w_item;
    logic [4:0]      r_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= 5'd2;
        end else if (i_cfg_we) begin
            r_points <= i_cfg_data;
        end
    end

    plin_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_mode              (i_mode),
        .i_entry_index       (i_entry_index),
        .i_entry_position    (i_entry_position),
        .i_entry_temperature (i_entry_temperature),
        .i_query_position    (i_query_position),
        .o_valid             (w_valid),
        .o_item              (w_item),
        .i_pop               (w_pop)
    );

    plin_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_points      (r_points),
        .i_valid       (w_valid),
        .i_item        (w_item),
        .o_pop         (w_pop),
        .empty         (empty),
        .pop           (pop),
        .o_temperature (o_temperature),
        .o_status      (o_status)
    );

    // An accepted transfer leaves at least one item waiting for the back end.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> w_valid)
        else $error("front queue lost an accepted item");

    // The back end never takes an item from an empty front queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid)
        else $error("back end popped an empty front queue");

    // A full front queue always presents an item.
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_valid)
        else $error("full front queue shows no item");

endmodule

// File: src/plin_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module plin_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/plin_front.sv
// Front end: accepts items, classifies loads and queries, queues them two deep.
// Depends on plin_pkg.
module plin_front #(
    parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_mode,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_entry_position,
    input  logic signed [31:0] i_entry_temperature,
    input  logic signed [31:0] i_query_position,
    output logic               o_valid,
    output plin_pkg::t_item    o_item,
    input  logic               i_pop
);

    plin_pkg::t_item r_q [2];
    plin_pkg::t_item w_new;
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_q[r_rp];

    always_comb begin
        w_new.mode              = i_mode;
        w_new.load_ok           = (32'(i_entry_index) < 32'(MAX_POINTS));
        w_new.entry_index       = i_entry_index;
        w_new.entry_position    = i_entry_position;
        w_new.entry_temperature = i_entry_temperature;
        w_new.query_position    = i_query_position;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: src/plin_back.sv
// Back end: table storage, segment scan, shift-add multiply, restoring divide.
// Depends on plin_pkg and plin_ram.
module plin_back #(
    parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_points,
    input  logic               i_valid,
    input  plin_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_temperature,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    plin_pkg::t_state r_state, n_state;

    logic [NW-1:0]      w_n;
    logic [NW-1:0]      r_i;
    logic [63:0]        w_rdata;
    logic               w_we, w_load_out;
    logic signed [31:0] w_rpos, w_rtemp;
    logic               w_le, w_last;

    logic signed [31:0] r_x;
    logic signed [31:0] r_x0, r_t0, r_x1, r_t1;
    logic [65:0]        r_acc, r_mc;
    logic [32:0]        r_mp, r_den, r_rem;
    logic               r_neg;
    logic [6:0]         r_cnt;
    logic signed [31:0] r_res;
    logic [1:0]         r_stat;
    logic               r_ovalid;
    logic signed [31:0] r_otemp;
    logic [1:0]         r_ostat;

    logic signed [32:0] w_den, w_dt, w_dx;
    logic [33:0]        w_rem_sh;
    logic               w_ge;
    logic signed [41:0] w_sum;

    // Clamp the configured point count into the supported range.
    always_comb begin
        if (i_points < 5'd2) begin
            w_n = NW'(2);
        end else if (32'(i_points) > 32'(MAX_POINTS)) begin
            w_n = NW'(MAX_POINTS);
        end else begin
            w_n = NW'(i_points);
        end
    end

    plin_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_item.entry_index)),
        .i_wdata ({i_item.entry_position, i_item.entry_temperature}),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rpos  = $signed(w_rdata[63:32]);
    assign w_rtemp = $signed(w_rdata[31:0]);
    assign w_le    = (r_x <= w_rpos);
    assign w_last  = (NW'(r_i + NW'(1)) == w_n);

    assign w_den    = {r_x1[31], r_x1} - {r_x0[31], r_x0};
    assign w_dt     = {r_t1[31], r_t1} - {r_t0[31], r_t0};
    assign w_dx     = {r_x[31], r_x} - {r_x0[31], r_x0};
    assign w_rem_sh = {r_rem, r_acc[65]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_sum    = r_neg ? (42'(r_t0) - $signed({2'b00, r_acc[39:0]}))
                            : (42'(r_t0) + $signed({2'b00, r_acc[39:0]}));

    always_comb begin
        n_state = r_state;
        case (r_state)
            plin_pkg::S_IDLE: begin
                if (i_valid && i_item.mode == plin_pkg::MODE_QUERY) begin
                    n_state = plin_pkg::S_RD;
                end
            end
            plin_pkg::S_RD:   n_state = plin_pkg::S_SCAN;
            plin_pkg::S_SCAN: begin
                if (r_i == '0) begin
                    n_state = plin_pkg::S_RD;
                end else if (w_le) begin
                    n_state = plin_pkg::S_PREP;
                end else if (w_last) begin
                    n_state = plin_pkg::S_OUT;
                end else begin
                    n_state = plin_pkg::S_RD;
                end
            end
            plin_pkg::S_PREP: begin
                n_state = (w_den == '0) ? plin_pkg::S_OUT : plin_pkg::S_MUL;
            end
            plin_pkg::S_MUL: begin
                if (r_cnt == 7'd1) begin
                    n_state = plin_pkg::S_DIV;
                end
            end
            plin_pkg::S_DIV: begin
                if (r_cnt == 7'd1) begin
                    n_state = plin_pkg::S_FIN;
                end
            end
            plin_pkg::S_FIN:  n_state = plin_pkg::S_OUT;
            plin_pkg::S_OUT: begin
                if (!r_ovalid || pop) begin
                    n_state = plin_pkg::S_IDLE;
                end
            end
            default: n_state = plin_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_we       = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            plin_pkg::S_IDLE: begin
                o_pop = i_valid;
                w_we  = i_valid && i_item.mode == plin_pkg::MODE_LOAD && i_item.load_ok;
            end
            plin_pkg::S_OUT: w_load_out = !r_ovalid || pop;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plin_pkg::S_IDLE;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == plin_pkg::S_IDLE) begin
                r_i <= '0;
            end else if (r_state == plin_pkg::S_SCAN && n_state == plin_pkg::S_RD) begin
                r_i <= NW'(r_i + NW'(1));
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            plin_pkg::S_IDLE: r_x <= i_item.query_position;
            plin_pkg::S_SCAN: begin
                if (r_i == '0 || !w_le) begin
                    r_x0 <= w_rpos;
                    r_t0 <= w_rtemp;
                end
                r_x1 <= w_rpos;
                r_t1 <= w_rtemp;
                r_res  <= w_rtemp;
                r_stat <= plin_pkg::ST_BEYOND;
            end
            plin_pkg::S_PREP: begin
                r_res  <= r_t1;
                r_stat <= plin_pkg::ST_ZERO_WIDTH;
                r_neg  <= (w_dt[32] != w_dx[32]) != w_den[32];
                r_mc   <= {33'd0, (w_dt[32] ? 33'(-w_dt) : 33'(w_dt))};
                r_mp   <= w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
                r_den  <= w_den[32] ? 33'(-w_den) : 33'(w_den);
                r_acc  <= '0;
                r_rem  <= '0;
                r_cnt  <= 7'd33;
            end
            plin_pkg::S_MUL: begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= {r_mc[64:0], 1'b0};
                r_mp  <= {1'b0, r_mp[32:1]};
                r_cnt <= (r_cnt == 7'd1) ? 7'd66 : r_cnt - 7'd1;
            end
            plin_pkg::S_DIV: begin
                // The accumulator shifts the dividend out at the top and the quotient in.
                r_rem <= w_ge ? 33'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[32:0];
                r_acc <= {r_acc[64:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
            end
            plin_pkg::S_FIN: begin
                if (|r_acc[65:40]) begin
                    r_res  <= r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    r_stat <= plin_pkg::ST_SAT;
                end else if (w_sum[41:31] != {11{w_sum[31]}}) begin
                    r_res  <= w_sum[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    r_stat <= plin_pkg::ST_SAT;
                end else begin
                    r_res  <= w_sum[31:0];
                    r_stat <= plin_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_otemp <= r_res;
            r_ostat <= r_stat;
        end
    end

    assign empty         = !r_ovalid;
    assign o_temperature = r_otemp;
    assign o_status      = r_ostat;

endmodule
